// ===== design/ffca_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit chunk allocator.
// -----------------------------------------------------------------------------
package ffca_pkg;

	localparam int MAX_CHUNKS_DEF  = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int TYPE_W   = 2;
	localparam int LEN_W    = 32;
	localparam int NEED_W   = 33;
	localparam int ALIGN_W  = 17;
	localparam int STATUS_W = 2;
	localparam int FREE_W   = 5;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// register select is paddr[2]
	localparam logic REG_ALIGNMENT = 1'b0;

	typedef enum logic [TYPE_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_GLOBAL = 2'd2,
		REQ_WINDOW = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_APPEND,
		S_DONE
	} fsm_state_t;

	// request broadcast to every cell
	typedef struct packed {
		logic              searching;
		logic              window;
		logic              full;
		logic [NEED_W-1:0] need;
		logic [LEN_W-1:0]  ws;
		logic [NEED_W-1:0] wend;
	} ffca_cmd_t;

	// fit report of a cell, all zero unless that cell hits
	typedef struct packed {
		logic             hit;
		logic             fail_full;
		logic             exact;
		logic             split;
		logic [LEN_W-1:0] grant;
		logic [LEN_W-1:0] lead;
	} ffca_hit_t;

endpackage

// ===== design/ffca_req_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffca_req_if
// Request channel: valid/ready plus one request item.
// -----------------------------------------------------------------------------
interface ffca_req_if;
	logic                          valid;
	logic                          ready;
	logic [ffca_pkg::TYPE_W-1:0]   req_type;
	logic [ffca_pkg::LEN_W-1:0]    request_size;
	logic [ffca_pkg::LEN_W-1:0]    window_start;
	logic [ffca_pkg::LEN_W-1:0]    window_size;

	modport source (output valid, req_type, request_size, window_start, window_size,
		input ready);
	modport sink (input valid, req_type, request_size, window_start, window_size,
		output ready);
endinterface

// ===== design/ffca_rsp_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffca_rsp_if
// Response channel: valid/ready plus one result item.
// -----------------------------------------------------------------------------
interface ffca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffca_pkg::STATUS_W-1:0] status;
	logic [ffca_pkg::LEN_W-1:0]    granted_offset;
	logic [ffca_pkg::FREE_W-1:0]   free_entries;

	modport source (output valid, status, granted_offset, free_entries, input ready);
	modport sink (input valid, status, granted_offset, free_entries, output ready);
endinterface

// ===== design/ffca_cell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffca_cell
// One table entry: holds a chunk, checks it for a fit while it has the
// search token, shrinks itself, and takes its neighbor's entry on a shift.
// -----------------------------------------------------------------------------
module ffca_cell #(
	parameter int MAX_CHUNKS  = 16,
	parameter int OFFSET_BITS = 32,
	parameter int IDX         = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ffca_pkg::ffca_cmd_t                   cmd,
	input  logic [$clog2(MAX_CHUNKS+1)-1:0]       count,
	input  logic                                  tok_in,
	output logic                                  tok_out,
	input  logic                                  shift,
	input  logic [$clog2(MAX_CHUNKS)-1:0]         shift_idx,
	input  logic                                  wr_en,
	input  logic [$clog2(MAX_CHUNKS)-1:0]         wr_idx,
	input  logic [OFFSET_BITS-1:0]                wr_start,
	input  logic [ffca_pkg::LEN_W-1:0]            wr_len,
	input  logic [OFFSET_BITS-1:0]                nxt_start,
	input  logic [ffca_pkg::LEN_W-1:0]            nxt_len,
	output logic [OFFSET_BITS-1:0]                start_o,
	output logic [ffca_pkg::LEN_W-1:0]            len_o,
	output ffca_pkg::ffca_hit_t                   hit_o,
	output logic [OFFSET_BITS-1:0]                hit_start_o
);
	import ffca_pkg::*;

	localparam int CW = $clog2(MAX_CHUNKS+1);
	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int OW = OFFSET_BITS;
	localparam int EW = ((OW > LEN_W) ? OW : LEN_W) + 1;

	logic          tok_q;
	logic [OW-1:0] start_q;
	logic [LEN_W-1:0] len_q;

	logic          active, hit, split, exact, fit, skip;
	logic [EW-1:0] s_x, l_x, e_x, ws_x, wend_x, need_x, ws_mod_x;
	logic [EW-1:0] cs_x, ce_x, avail_x, lead_x, rest_x, base_x;
	logic [OW-1:0] new_start;
	logic [LEN_W-1:0] new_len, grant;

	always_comb begin
		active   = CW'(IDX) < count;
		s_x      = EW'(start_q);
		l_x      = EW'(len_q);
		e_x      = s_x + l_x;
		ws_x     = EW'(cmd.ws);
		wend_x   = EW'(cmd.wend);
		need_x   = EW'(cmd.need);
		ws_mod_x = EW'(OW'(cmd.ws));

		// window clipping; a chunk that only touches the window is still tried
		skip     = (e_x < ws_x) || (s_x > wend_x);
		split    = cmd.window && (s_x < ws_x);
		cs_x     = split ? ws_x : s_x;
		ce_x     = (e_x > wend_x) ? wend_x : e_x;
		avail_x  = ce_x - cs_x;
		lead_x   = split ? (ws_x - s_x) : '0;
		rest_x   = l_x - lead_x;

		if (cmd.window) begin
			fit   = !skip && (avail_x >= need_x);
			exact = rest_x == need_x;
		end else begin
			fit   = l_x >= need_x;
			exact = l_x == need_x;
		end

		base_x    = split ? ws_mod_x : s_x;
		new_start = OW'(base_x + need_x);
		new_len   = LEN_W'(rest_x - need_x);
		grant     = cmd.window ? LEN_W'(base_x - ws_x) : LEN_W'(s_x);

		hit     = tok_q && cmd.searching && active && fit;
		tok_out = tok_q && cmd.searching && active && !fit;

		hit_o.hit       = hit;
		hit_o.fail_full = hit && split && !exact && cmd.full;
		hit_o.exact     = hit && exact;
		hit_o.split     = hit && split;
		hit_o.grant     = hit ? grant : '0;
		hit_o.lead      = hit ? LEN_W'(lead_x) : '0;
		hit_start_o     = hit ? start_q : '0;
		start_o         = start_q;
		len_o           = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IW'(IDX))) begin
			start_q <= wr_start;
			len_q   <= wr_len;
		end else if (shift && (IW'(IDX) >= shift_idx)) begin
			start_q <= nxt_start;
			len_q   <= nxt_len;
		end else if (hit && !hit_o.fail_full && !exact) begin
			start_q <= new_start;
			len_q   <= new_len;
		end
	end

endmodule

// ===== design/first_fit_chunk_allocator.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_chunk_allocator
// First-fit free-chunk table built as a row of entry cells with a search
// token that moves one cell per cycle.
// -----------------------------------------------------------------------------
//  channel | dir | handshake           | item
//  req     | in  | valid/ready         | req_type, request_size, window_*
//  rsp     | out | valid/ready         | status, granted_offset, free_entries
//  apb     | in  | psel/penable/pready | alignment register at byte 0
//
// Clear and add go from idle to done and then to the output register. A reserve
// walks the token from entry 0 up to the chosen entry (or the entry count on
// a miss), then takes a removal shift and a leading-piece append where needed,
// and then waits in done until the output register is free to take the result.
// Reset empties the table and clears alignment; entries are not cleared.
// A new request is taken once the previous result sits in the output
// register, even while rsp is stalled.
// -----------------------------------------------------------------------------
module first_fit_chunk_allocator #(
	parameter int MAX_CHUNKS  = ffca_pkg::MAX_CHUNKS_DEF,
	parameter int OFFSET_BITS = ffca_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ffca_req_if.sink                      req,
	ffca_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffca_pkg::ADDR_W-1:0]   paddr,
	input  logic [ffca_pkg::DATA_W-1:0]   pwdata,
	output logic [ffca_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ffca_pkg::*;

	localparam int CW = $clog2(MAX_CHUNKS+1);
	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int OW = OFFSET_BITS;

	fsm_state_t state_q, state_d;

	logic [CW-1:0]      count_q, idx_q;
	logic [ALIGN_W-1:0] align_q;
	logic               window_q;
	logic [NEED_W-1:0]  need_q, wend_q;
	logic [LEN_W-1:0]   ws_q;
	status_t            status_q;
	logic [LEN_W-1:0]   grant_q, lead_q;
	logic               split_q;
	logic [OW-1:0]      hstart_q;

	logic               ov_q;
	logic [STATUS_W-1:0] ost_q;
	logic [LEN_W-1:0]   ogr_q;
	logic [FREE_W-1:0]  ofree_q;

	logic               accept, is_reserve, launch, shift, wr_en, out_load;
	logic [IW-1:0]      wr_idx;
	logic [OW-1:0]      wr_start;
	logic [LEN_W-1:0]   wr_len;
	logic [NEED_W-1:0]  need_in, align_x, size_x;
	req_type_t          rtype;
	ffca_cmd_t          cmd;
	ffca_hit_t          hit_all;

	logic [MAX_CHUNKS-1:0] tok_in, tok_out, hit_vec;
	logic [OW-1:0]         start_w [MAX_CHUNKS];
	logic [LEN_W-1:0]      len_w [MAX_CHUNKS];
	logic [OW-1:0]         hstart_w [MAX_CHUNKS];
	ffca_hit_t             hit_w [MAX_CHUNKS];
	logic [OW-1:0]         hstart_all;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
		logic [OW-1:0]    nxt_s;
		logic [LEN_W-1:0] nxt_l;
		if (i == MAX_CHUNKS - 1) begin : g_last
			assign nxt_s = start_w[i];
			assign nxt_l = len_w[i];
		end else begin : g_mid
			assign nxt_s = start_w[i+1];
			assign nxt_l = len_w[i+1];
		end
		if (i == 0) begin : g_head
			assign tok_in[i] = launch;
		end else begin : g_body
			assign tok_in[i] = tok_out[i-1];
		end

		ffca_cell #(
			.MAX_CHUNKS  (MAX_CHUNKS),
			.OFFSET_BITS (OFFSET_BITS),
			.IDX         (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.count       (count_q),
			.tok_in      (tok_in[i]),
			.tok_out     (tok_out[i]),
			.shift       (shift),
			.shift_idx   (idx_q[IW-1:0]),
			.wr_en       (wr_en),
			.wr_idx      (wr_idx),
			.wr_start    (wr_start),
			.wr_len      (wr_len),
			.nxt_start   (nxt_s),
			.nxt_len     (nxt_l),
			.start_o     (start_w[i]),
			.len_o       (len_w[i]),
			.hit_o       (hit_w[i]),
			.hit_start_o (hstart_w[i])
		);
		assign hit_vec[i] = hit_w[i].hit;
	end

	// at most one cell reports, so OR merges the reports
	always_comb begin
		hit_all    = '0;
		hstart_all = '0;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			hit_all    = ffca_hit_t'(hit_all | hit_w[i]);
			hstart_all = hstart_all | hstart_w[i];
		end
	end

	// ---------------- request decode ----------------
	always_comb begin
		rtype      = req_type_t'(req.req_type);
		accept     = req.valid && req.ready;
		is_reserve = (rtype == REQ_GLOBAL) || (rtype == REQ_WINDOW);
		align_x    = NEED_W'(align_q);
		size_x     = NEED_W'(req.request_size);
		if (align_q == '0) begin
			need_in = size_x;
		end else begin
			need_in = (size_x + align_x - NEED_W'(1)) & ~(align_x - NEED_W'(1));
		end

		cmd.searching = state_q == S_SEARCH;
		cmd.window    = window_q;
		cmd.full      = count_q >= CW'(MAX_CHUNKS);
		cmd.need      = need_q;
		cmd.ws        = ws_q;
		cmd.wend      = wend_q;
	end

	// ---------------- control ----------------
	always_comb begin
		state_d  = state_q;
		launch   = 1'b0;
		shift    = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = count_q[IW-1:0];
		wr_start = '0;
		wr_len   = req.request_size;
		out_load = 1'b0;
		req.ready = state_q == S_IDLE;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					if (rtype == REQ_ADD && count_q < CW'(MAX_CHUNKS)) begin
						wr_en = 1'b1;
					end
					if (is_reserve && count_q != '0) begin
						launch  = 1'b1;
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (idx_q >= count_q) begin
					state_d = S_DONE;
				end else if (hit_all.hit) begin
					if (hit_all.fail_full) begin
						state_d = S_DONE;
					end else if (hit_all.exact) begin
						state_d = S_SHIFT;
					end else if (hit_all.split) begin
						state_d = S_APPEND;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				shift   = 1'b1;
				state_d = split_q ? S_APPEND : S_DONE;
			end
			S_APPEND: begin
				wr_en    = 1'b1;
				wr_start = hstart_q;
				wr_len   = lead_q;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			align_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (accept && rtype == REQ_CLEAR) begin
				count_q <= '0;
				align_q <= '0;
			end else if (psel && penable && pwrite && pready && paddr[2] == REG_ALIGNMENT) begin
				align_q <= pwdata[ALIGN_W-1:0];
			end
			if (wr_en) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (shift) begin
				count_q <= CW'(count_q - 1'b1);
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					window_q <= rtype == REQ_WINDOW;
					need_q   <= need_in;
					ws_q     <= req.window_start;
					wend_q   <= NEED_W'(req.window_start) + NEED_W'(req.window_size);
					idx_q    <= '0;
					grant_q  <= '0;
					split_q  <= 1'b0;
					if (rtype == REQ_ADD && count_q >= CW'(MAX_CHUNKS)) begin
						status_q <= ST_FULL;
					end else if (is_reserve && count_q == '0) begin
						status_q <= ST_NO_FIT;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_SEARCH: begin
				if (idx_q >= count_q) begin
					status_q <= ST_NO_FIT;
				end else if (hit_all.hit) begin
					if (hit_all.fail_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						grant_q  <= hit_all.grant;
					end
					split_q  <= hit_all.split;
					lead_q   <= hit_all.lead;
					hstart_q <= hstart_all;
				end else begin
					idx_q <= CW'(idx_q + 1'b1);
				end
			end
			S_DONE: begin
				if (out_load) begin
					ost_q   <= status_q;
					ogr_q   <= grant_q;
					ofree_q <= FREE_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = ov_q;
	assign rsp.status         = ost_q;
	assign rsp.granted_offset = ogr_q;
	assign rsp.free_entries   = ofree_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ALIGNMENT) ? DATA_W'(align_q) : '0;

	// ---------------- checks ----------------
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell reports a fit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CHUNKS))
		else $error("entry count above table depth");

	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_reserve && count_q != '0) |=> (state_q == S_SEARCH && tok_in[0] == 1'b0))
		else $error("reserve on a non-empty table did not start a search");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> (count_q != '0 && idx_q < count_q))
		else $error("removal shift outside the filled entries");

endmodule

// ===== verif/tb_first_fit_chunk_allocator.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_first_fit_chunk_allocator
// Self-checking bench for the first-fit chunk allocator. A driver feeds
// requests from a queue, and a predictor of the free-chunk table computes each
// expected result when a request is taken. A monitor compares every result
// with the oldest expected one. Both sides idle at random, and the result side
// holds off once for a long stretch. The alignment register is written over
// APB between phases, while the block is idle.
// -----------------------------------------------------------------------------
module tb_first_fit_chunk_allocator;
	import ffca_pkg::*;

	localparam int          TABLE_DEPTH = MAX_CHUNKS_DEF;
	localparam int          DRAIN_WAIT  = TABLE_DEPTH + 24;
	localparam int          DOG_LIMIT   = 4000;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	typedef struct {
		req_type_t   kind;
		logic [31:0] size;
		logic [31:0] win_start;
		logic [31:0] win_size;
	} alloc_req_t;

	typedef struct {
		status_t     status;
		logic [31:0] offset;
		logic [4:0]  free_cnt;
	} alloc_res_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	ffca_req_if req_ch ();
	ffca_rsp_if rsp_ch ();

	first_fit_chunk_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// predicted table
	longint unsigned chunk_off[TABLE_DEPTH];
	longint unsigned chunk_len[TABLE_DEPTH];
	int              chunk_cnt;
	longint unsigned align_val;

	alloc_req_t pending_reqs[$];
	alloc_res_t expected_res[$];
	alloc_req_t cur_req;
	int         errors;
	int         req_gap;
	int         rsp_gap;
	int         results_seen;
	int         hold_left;
	bit         hold_done;
	bit         calm;
	int         quiet_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void drop_chunk(input int idx);
		for (int k = idx; k + 1 < chunk_cnt; k++) begin
			chunk_off[k] = chunk_off[k+1];
			chunk_len[k] = chunk_len[k+1];
		end
		chunk_cnt--;
	endfunction

	function automatic int take_global(input longint unsigned need,
			output longint unsigned grant);
		grant = 0;
		for (int i = 0; i < chunk_cnt; i++) begin
			if (chunk_len[i] > need) begin
				grant = chunk_off[i];
				chunk_off[i] = (chunk_off[i] + need) & 64'hFFFF_FFFF;
				chunk_len[i] -= need;
				return ST_OK;
			end
			if (chunk_len[i] == need) begin
				grant = chunk_off[i];
				drop_chunk(i);
				return ST_OK;
			end
		end
		return ST_NO_FIT;
	endfunction

	function automatic int take_window(input longint unsigned need,
			input longint unsigned ws, input longint unsigned wr,
			output longint unsigned grant);
		longint unsigned wend, s, len, e, avail, lead, rest;
		bit split, exact;
		grant = 0;
		wend = ws + wr;
		for (int i = 0; i < chunk_cnt; i++) begin
			s = chunk_off[i];
			len = chunk_len[i];
			e = s + len;
			if (e < ws || s > wend)
				continue;
			avail = len;
			if (s < ws)
				avail -= ws - s;
			if (e > wend)
				avail -= e - wend;
			if (avail >= need) begin
				split = s < ws;
				lead = split ? ws - s : 0;
				rest = len - lead;
				exact = rest == need;
				if (split && !exact && chunk_cnt >= TABLE_DEPTH)
					return ST_FULL;
				if (split) begin
					s = ws;
					chunk_off[i] = s;
					chunk_len[i] = rest;
				end
				grant = (s - ws) & 64'hFFFF_FFFF;
				if (exact) begin
					drop_chunk(i);
				end else begin
					chunk_off[i] = (s + need) & 64'hFFFF_FFFF;
					chunk_len[i] = rest - need;
				end
				if (split && chunk_cnt < TABLE_DEPTH) begin
					chunk_off[chunk_cnt] = (ws - lead) & 64'hFFFF_FFFF;
					chunk_len[chunk_cnt] = lead & 64'hFFFF_FFFF;
					chunk_cnt++;
				end
				return ST_OK;
			end
		end
		return ST_NO_FIT;
	endfunction

	function automatic alloc_res_t apply_request(input alloc_req_t r);
		alloc_res_t res;
		longint unsigned need, grant;
		int st;
		st = ST_OK;
		grant = 0;
		need = r.size;
		if (align_val != 0)
			need = (need + align_val - 1) & ~(align_val - 1);
		case (r.kind)
			REQ_CLEAR: begin
				chunk_cnt = 0;
				align_val = 0;
			end
			REQ_ADD: begin
				if (chunk_cnt >= TABLE_DEPTH) begin
					st = ST_FULL;
				end else begin
					chunk_off[chunk_cnt] = 0;
					chunk_len[chunk_cnt] = r.size;
					chunk_cnt++;
				end
			end
			default: begin
				if (chunk_cnt == 0)
					st = ST_NO_FIT;
				else if (r.kind == REQ_GLOBAL)
					st = take_global(need, grant);
				else
					st = take_window(need, r.win_start, r.win_size, grant);
			end
		endcase
		if (st != ST_OK)
			grant = 0;
		res.status = status_t'(st);
		res.offset = grant[31:0];
		res.free_cnt = chunk_cnt[4:0];
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_CLEAR;
			req_ch.request_size <= '0;
			req_ch.window_start <= '0;
			req_ch.window_size <= '0;
			req_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_res = {expected_res, apply_request(cur_req)};
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (req_gap > 0) begin
					req_ch.valid <= 1'b0;
					req_gap--;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= cur_req.kind;
					req_ch.request_size <= cur_req.size;
					req_ch.window_start <= cur_req.win_start;
					req_ch.window_size <= cur_req.win_size;
					req_gap = calm ? 0 : $urandom_range(0, 4);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		alloc_res_t exp_r;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_gap = 0;
			results_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (expected_res.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: status %0d offset %h free %0d",
						$time, rsp_ch.status, rsp_ch.granted_offset, rsp_ch.free_entries);
				end else begin
					exp_r = expected_res.pop_front();
					if (rsp_ch.status !== exp_r.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							exp_r.status, rsp_ch.status);
					end
					if (rsp_ch.granted_offset !== exp_r.offset) begin
						errors++;
						$display("%0t: granted_offset expected %h actual %h", $time,
							exp_r.offset, rsp_ch.granted_offset);
					end
					if (rsp_ch.free_entries !== exp_r.free_cnt) begin
						errors++;
						$display("%0t: free_entries expected %0d actual %0d", $time,
							exp_r.free_cnt, rsp_ch.free_entries);
					end
				end
				rsp_gap = calm ? 0 : $urandom_range(0, 4);
				// one long hold so the request side backs up
				if (results_seen == 120 && !hold_done) begin
					hold_left = 300;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= DOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, DOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_req(input req_type_t kind, input logic [31:0] size,
			input logic [31:0] ws, input logic [31:0] wr);
		alloc_req_t r;
		r.kind = kind;
		r.size = size;
		r.win_start = ws;
		r.win_size = wr;
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_alignment(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ADDR_W{1'b0}} | (REG_ALIGNMENT << 2);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		align_val = value[ALIGN_W-1:0];
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return ALL_ONES - $urandom_range(0, 3);
			2:       return $urandom_range(0, 3);
			default: return $urandom_range(0, 4096);
		endcase
	endfunction

	task automatic add_random(input int count);
		int pick;
		logic [31:0] size;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			size = pick_value();
			if (pick < 3)
				add_req(REQ_CLEAR, $urandom(), $urandom(), $urandom());
			else if (pick < 22)
				add_req(REQ_ADD, ($urandom_range(0, 3) == 0) ? $urandom() :
					$urandom_range(256, 65536), $urandom(), $urandom());
			else if (pick < 55)
				add_req(REQ_GLOBAL, size, $urandom(), $urandom());
			else
				add_req(REQ_WINDOW, size, pick_value(), pick_value());
		end
	endtask

	initial begin
		logic [31:0] align_list[6];
		align_list = '{32'd1, 32'd65536, 32'd8, 32'd3, 32'd4096, 32'd0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		chunk_cnt = 0;
		align_val = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_alignment(32'd0);
		// empty table, full-size chunk, zero sizes, exact removal
		add_req(REQ_GLOBAL, 32'd10, 32'd0, 32'd0);
		add_req(REQ_WINDOW, 32'd10, 32'd0, 32'd100);
		add_req(REQ_ADD, ALL_ONES, 32'd0, 32'd0);
		add_req(REQ_GLOBAL, 32'd0, 32'd0, 32'd0);
		add_req(REQ_GLOBAL, ALL_ONES, 32'd0, 32'd0);
		add_req(REQ_ADD, 32'd0, 32'd0, 32'd0);
		add_req(REQ_ADD, 32'd1000, 32'd0, 32'd0);
		add_req(REQ_GLOBAL, 32'd0, 32'd0, 32'd0);
		// leading piece appended, window miss, touching window, extremes
		add_req(REQ_WINDOW, 32'd10, 32'd50, 32'd20);
		add_req(REQ_WINDOW, 32'd5, 32'd2000, 32'd10);
		add_req(REQ_WINDOW, 32'd0, 32'd60, 32'd0);
		add_req(REQ_WINDOW, ALL_ONES, ALL_ONES, ALL_ONES);
		// add eight more chunks, then split a chunk and add one more
		for (int i = 0; i < 8; i++)
			add_req(REQ_ADD, 32'd500, 32'd0, 32'd0);
		add_req(REQ_WINDOW, 32'd10, 32'd100, 32'd50);
		add_req(REQ_ADD, 32'd7, 32'd0, 32'd0);
		wait_idle();
		write_alignment(32'd65536);
		add_req(REQ_CLEAR, 32'd0, 32'd0, 32'd0);
		wait_idle();
		write_alignment(32'd65536);
		add_req(REQ_ADD, ALL_ONES, 32'd0, 32'd0);
		add_req(REQ_GLOBAL, ALL_ONES, 32'd0, 32'd0);
		wait_idle();
		write_alignment(32'd3);
		add_req(REQ_GLOBAL, 32'd5, 32'd0, 32'd0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			calm = (p == 2);
			write_alignment(align_list[p]);
			add_random(88);
			wait_idle();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
